@@ rtl/wsd_pkg.sv @@
// wsd_pkg: shared types and constants of the websocket frame deframer
// used by every module under rtl except wsd_checker; depends on nothing

package wsd_pkg;

   // header field positions and length codes
   localparam logic [7:0] OPCODE_MASK  = 8'h0F;
   localparam logic [7:0] MASK_BIT     = 8'h80;
   localparam logic [7:0] LEN_MASK     = 8'h7F;
   localparam logic [6:0] LEN_CODE_16  = 7'd126;
   localparam logic [6:0] LEN_CODE_64  = 7'd127;
   localparam logic [15:0] LIMIT_RESET = 16'd4096;

   // one received byte with its restart flag
   typedef struct packed {
      logic       restart;
      logic [7:0] rx_byte;
   } item_type;

   // one result transaction
   typedef struct packed {
      logic [15:0] payload_length;
      logic        dropped;
      logic        last;
      logic        first;
      logic [3:0]  opcode;
      logic        has_data;
      logic [7:0]  data_byte;
   } result_type;

   // item or result travelling between stages
   typedef struct packed {
      logic     valid;
      item_type item;
   } item_stage_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } result_stage_type;

endpackage

@@ rtl/wsd_in_reg.sv @@
// wsd_in_reg: input register of the deframer, one received byte deep
// depends on wsd_pkg

module wsd_in_reg
   import wsd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   input  item_type       in_item,
   output logic           in_ready,
   input  logic           take,
   output item_stage_type stage
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // empty, or emptied by the parser in this cycle
   assign in_ready = !valid_ff || take;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;

endmodule

@@ rtl/wsd_parser.sv @@
// wsd_parser: frame header parsing, length check and payload counting
// one byte per cycle while fire is high; depends on wsd_pkg

module wsd_parser
   import wsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      buffer_bytes,
   input  item_type         item,
   input  logic             fire,
   output result_stage_type res
);

   logic [3:0]  header_count_ff, header_count_in;
   logic [3:0]  frame_opcode_ff, frame_opcode_in;
   logic        mask_present_ff, mask_present_in;
   logic [6:0]  length_code_ff, length_code_in;
   logic [63:0] length_accum_ff, length_accum_in;
   logic [63:0] payload_remaining_ff, payload_remaining_in;
   logic        in_payload_ff, in_payload_in;
   logic        skip_frame_ff, skip_frame_in;
   logic        first_pending_ff, first_pending_in;

   // header length from mask flag and length code
   function automatic logic [3:0] hdr_len(input logic mask, input logic [6:0] code);
      logic [3:0] ext;
      ext = (code == LEN_CODE_16) ? 4'd2 : ((code == LEN_CODE_64) ? 4'd8 : 4'd0);
      return 4'd2 + ext + (mask ? 4'd4 : 4'd0);
   endfunction

   // next state and result for the byte in the input register
   always_comb begin
      logic [7:0]  b;
      logic [3:0]  ext;
      logic [3:0]  hlen;
      logic [63:0] rem_dec;
      logic        finish;
      logic        too_big;

      b       = item.rx_byte;
      finish  = 1'b0;
      too_big = 1'b0;
      ext     = 4'd0;
      hlen    = 4'd0;

      header_count_in      = header_count_ff;
      frame_opcode_in      = frame_opcode_ff;
      mask_present_in      = mask_present_ff;
      length_code_in       = length_code_ff;
      length_accum_in      = length_accum_ff;
      payload_remaining_in = payload_remaining_ff;
      in_payload_in        = in_payload_ff;
      skip_frame_in        = skip_frame_ff;
      first_pending_in     = first_pending_ff;

      res.valid                 = 1'b0;
      res.result.data_byte      = 8'd0;
      res.result.has_data       = 1'b0;
      res.result.first          = 1'b1;
      res.result.last           = 1'b1;
      res.result.dropped        = 1'b0;
      res.result.payload_length = 16'd0;

      // restart discards the partial frame
      if (item.restart) begin
         header_count_in      = 4'd0;
         mask_present_in      = 1'b0;
         length_code_in       = 7'd0;
         length_accum_in      = 64'd0;
         payload_remaining_in = 64'd0;
         in_payload_in        = 1'b0;
         skip_frame_in        = 1'b0;
         first_pending_in     = 1'b1;
      end

      rem_dec = payload_remaining_in - 64'd1;

      if (in_payload_in) begin
         // payload byte, passed on or skipped
         payload_remaining_in = rem_dec;
         if (skip_frame_in) begin
            if (rem_dec == 64'd0) begin
               res.valid          = 1'b1;
               res.result.dropped = 1'b1;
            end
         end else begin
            res.valid                 = 1'b1;
            res.result.data_byte      = b;
            res.result.has_data       = 1'b1;
            res.result.first          = first_pending_in;
            res.result.last           = (rem_dec == 64'd0);
            res.result.payload_length = length_accum_in[15:0];
            first_pending_in          = 1'b0;
         end
         if (rem_dec == 64'd0) begin
            header_count_in  = 4'd0;
            mask_present_in  = 1'b0;
            length_code_in   = 7'd0;
            length_accum_in  = 64'd0;
            in_payload_in    = 1'b0;
            skip_frame_in    = 1'b0;
            first_pending_in = 1'b1;
         end
      end else if (header_count_in == 4'd0) begin
         // first header byte: opcode
         frame_opcode_in = b[3:0] & OPCODE_MASK[3:0];
         header_count_in = 4'd1;
      end else if (header_count_in == 4'd1) begin
         // second header byte: mask flag and length code
         mask_present_in = (b & MASK_BIT) != 8'd0;
         length_code_in  = b[6:0] & LEN_MASK[6:0];
         length_accum_in = (length_code_in < LEN_CODE_16) ? {57'd0, length_code_in} : 64'd0;
         header_count_in = 4'd2;
         finish          = (hdr_len(mask_present_in, length_code_in) == 4'd2);
      end else begin
         // extended length bytes, then masking key bytes
         ext = (length_code_in == LEN_CODE_16) ? 4'd2 :
               ((length_code_in == LEN_CODE_64) ? 4'd8 : 4'd0);
         if ((header_count_in - 4'd2) < ext) begin
            length_accum_in = {length_accum_in[55:0], b};
         end
         header_count_in = header_count_in + 4'd1;
         finish          = (header_count_in == hdr_len(mask_present_in, length_code_in));
      end

      // header done: size check and the empty payload case
      if (finish) begin
         hlen    = hdr_len(mask_present_in, length_code_in);
         too_big = (length_accum_in[63:16] != 48'd0) ||
                   (({1'b0, length_accum_in[15:0]} + {13'd0, hlen}) > {1'b0, buffer_bytes});
         if (length_accum_in == 64'd0) begin
            res.valid          = 1'b1;
            res.result.dropped = too_big;
            header_count_in    = 4'd0;
            mask_present_in    = 1'b0;
            length_code_in     = 7'd0;
            length_accum_in    = 64'd0;
            payload_remaining_in = 64'd0;
            in_payload_in      = 1'b0;
            skip_frame_in      = 1'b0;
            first_pending_in   = 1'b1;
         end else begin
            payload_remaining_in = length_accum_in;
            in_payload_in        = 1'b1;
            skip_frame_in        = too_big;
         end
      end

      res.result.opcode = frame_opcode_in;
      res.valid         = res.valid && fire;
   end

   // parser state, updated once per processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff      <= 4'd0;
         frame_opcode_ff      <= 4'd0;
         mask_present_ff      <= 1'b0;
         length_code_ff       <= 7'd0;
         length_accum_ff      <= 64'd0;
         payload_remaining_ff <= 64'd0;
         in_payload_ff        <= 1'b0;
         skip_frame_ff        <= 1'b0;
         first_pending_ff     <= 1'b1;
      end else if (fire) begin
         header_count_ff      <= header_count_in;
         frame_opcode_ff      <= frame_opcode_in;
         mask_present_ff      <= mask_present_in;
         length_code_ff       <= length_code_in;
         length_accum_ff      <= length_accum_in;
         payload_remaining_ff <= payload_remaining_in;
         in_payload_ff        <= in_payload_in;
         skip_frame_ff        <= skip_frame_in;
         first_pending_ff     <= first_pending_in;
      end
   end

endmodule

@@ rtl/wsd_out_reg.sv @@
// wsd_out_reg: result register of the deframer with ready back-pressure
// depends on wsd_pkg

module wsd_out_reg
   import wsd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  result_stage_type res,
   output logic             load,
   output logic             out_valid,
   output result_type       out_result,
   input  logic             out_ready
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // free, or being emptied downstream in this cycle
   assign load     = !valid_ff || out_ready;
   assign valid_in = load ? res.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= res.result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// websocket_frame_deframer: top level, byte stream in, tagged payload bytes out
// depends on wsd_pkg, wsd_in_reg, wsd_parser, wsd_out_reg
//
// channel  direction  handshake             contents
// req      in         req_tvalid/tready     tdata rx_byte, tuser restart
// rsp      out        rsp_tvalid/tready     tdata byte+length, tuser flags, tlast
// csr      in         csr_we                csr_wdata = buffer_bytes
//
// one byte per cycle sustained while rsp is ready; a byte is held in the input register,
// parsed combinationally, and its result is then loaded into the result register
// synchronous reset empties both registers and clears the parser state, limit 4096
// a stalled rsp holds its result; req stays ready while the result register
// can move, so stalls reach upstream only when both registers are full

module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // slave side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] restart
   // master side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_byte, [23:8] payload_length
   output logic [6:0]  rsp_tuser,   // [0] has_data, [4:1] opcode, [5] first, [6] dropped
   output logic        rsp_tlast,   // last
   // configuration
   input  logic        csr_we,
   input  logic [15:0] csr_wdata    // buffer_bytes
);

   logic [15:0]      buffer_bytes_ff;
   item_type         in_item;
   item_stage_type   stage;
   result_stage_type res;
   result_type       out_result;
   logic             load;
   logic             fire;

   // frame size limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_bytes_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         buffer_bytes_ff <= csr_wdata;
      end
   end

   assign in_item.rx_byte = req_tdata;
   assign in_item.restart = req_tuser;

   // byte moves into processing when the result register can take it
   assign fire = stage.valid && load;

   wsd_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_item  (in_item),
      .in_ready (req_tready),
      .take     (fire),
      .stage    (stage)
   );

   wsd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .buffer_bytes (buffer_bytes_ff),
      .item         (stage.item),
      .fire         (fire),
      .res          (res)
   );

   wsd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res        (res),
      .load       (load),
      .out_valid  (rsp_tvalid),
      .out_result (out_result),
      .out_ready  (rsp_tready)
   );

   // result packing
   assign rsp_tdata = {out_result.payload_length, out_result.data_byte};
   assign rsp_tuser = {out_result.dropped, out_result.first, out_result.opcode,
                       out_result.has_data};
   assign rsp_tlast = out_result.last;

endmodule

@@ rtl/wsd_checker.sv @@
// wsd_checker: port-level assertions for websocket_frame_deframer
// bound to the top level; depends on the top level port list only

module wsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [6:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp transaction changed while stalled");

   // a transaction without data closes a whole frame and carries zeros
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && rsp_tuser[5] &&
      rsp_tdata[7:0] == 8'd0 && rsp_tdata[23:8] == 16'd0)
      else $error("data-less result is not a complete empty frame");

   // a dropped frame never carries payload
   a_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[6] |-> !rsp_tuser[0])
      else $error("dropped frame carries payload");

   // after reset no result is pending and input is accepted
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("state not cleared by reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
